[rtl/spc_pkg.sv]
// Shared widths, codes and control types of the spectral partitioned convolver.
package spc_pkg;

  localparam int DATA_W         = 24;
  localparam int COEF_IDX_W     = 10;
  localparam int FS_W           = 7;
  localparam int PC_CFG_W       = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 7;
  localparam int FRAC_SHIFT     = 21;
  localparam int FS_MIN         = 4;
  localparam int DEF_MAX_FRAMES = 64;
  localparam int DEF_MAX_PARTS  = 16;
  localparam int IN_TDATA_W     = 112;
  localparam int OUT_TDATA_W    = 48;

  localparam logic [FS_W-1:0]     FS_RESET = 7'd64;
  localparam logic [PC_CFG_W-1:0] PC_RESET = 5'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 2'd1;

  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clr;  // zero both accumulators
    logic en;   // multiply the operands this cycle
    logic im;   // product goes to the imaginary accumulator
    logic neg;  // product is subtracted
  } mac_ctrl_t;

endpackage

[rtl/spc_ram.sv]
// Generic simple dual-port RAM with registered read data.
module spc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/spc_mac.sv]
// Shared complex multiply-accumulate unit: one real product per cycle, registered.
module spc_mac #(
  parameter int ACC_W = 54
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  spc_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [spc_pkg::DATA_W-1:0] a_i,
  input  logic signed [spc_pkg::DATA_W-1:0] b_i,
  output logic signed [ACC_W-1:0]          acc_r_o,
  output logic signed [ACC_W-1:0]          acc_i_o
);

  import spc_pkg::*;

  localparam int PROD_W = 2 * DATA_W;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     pv_q, pv_d;
  logic                     pim_q, pim_d;
  logic                     pneg_q, pneg_d;
  logic signed [ACC_W-1:0]  acc_r_q, acc_r_d;
  logic signed [ACC_W-1:0]  acc_i_q, acc_i_d;
  logic signed [ACC_W-1:0]  term;

  always_comb begin
    prod_d  = prod_q;
    pim_d   = pim_q;
    pneg_d  = pneg_q;
    pv_d    = ctrl_i.en;
    acc_r_d = acc_r_q;
    acc_i_d = acc_i_q;
    term    = pneg_q ? -ACC_W'(prod_q) : ACC_W'(prod_q);
    if (ctrl_i.en) begin
      prod_d = PROD_W'(a_i) * PROD_W'(b_i);
      pim_d  = ctrl_i.im;
      pneg_d = ctrl_i.neg;
    end
    if (ctrl_i.clr) begin
      acc_r_d = '0;
      acc_i_d = '0;
      pv_d    = 1'b0;
    end else if (pv_q) begin
      // fold the product of the previous cycle
      if (pim_q) begin
        acc_i_d = acc_i_q + term;
      end else begin
        acc_r_d = acc_r_q + term;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      pim_q   <= 1'b0;
      pneg_q  <= 1'b0;
      prod_q  <= '0;
      acc_r_q <= '0;
      acc_i_q <= '0;
    end else begin
      pv_q    <= pv_d;
      pim_q   <= pim_d;
      pneg_q  <= pneg_d;
      prod_q  <= prod_d;
      acc_r_q <= acc_r_d;
      acc_i_q <= acc_i_d;
    end
  end

  assign acc_r_o = acc_r_q;
  assign acc_i_o = acc_i_q;

endmodule

[rtl/spc_div.sv]
// Bit-serial normalizing divider: acc / (pc * 2^21), truncated toward zero, saturated.
module spc_div #(
  parameter int ACC_W = 54,
  parameter int PCW   = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [PCW-1:0]                    pc_i,
  input  logic signed [ACC_W-1:0]           acc_r_i,
  input  logic signed [ACC_W-1:0]           acc_i_i,
  output logic                              done_o,
  output logic signed [spc_pkg::DATA_W-1:0] q_r_o,
  output logic signed [spc_pkg::DATA_W-1:0] q_i_o
);

  import spc_pkg::*;

  localparam int MAG_W = ACC_W - FRAC_SHIFT;
  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [DATA_W-1:0] POS_LIM = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_LIM = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [ACC_W-1:0] acc_in [2];
  logic [ACC_W-1:0]        absv   [2];
  logic [MAG_W-1:0]        rem_q  [2];
  logic [MAG_W-1:0]        rem_d  [2];
  logic [DATA_W-1:0]       quo_q  [2];
  logic [DATA_W-1:0]       quo_d  [2];
  logic                    neg_q  [2];
  logic                    neg_d  [2];
  logic                    sat_q  [2];
  logic                    sat_d  [2];
  logic [DATA_W-1:0]       res    [2];
  logic [MAG_W-1:0]        dsor_q, dsor_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic                    ge;

  assign acc_in[0] = acc_r_i;
  assign acc_in[1] = acc_i_i;

  always_comb begin
    dsor_d = dsor_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    ge     = 1'b0;
    for (int l = 0; l < 2; l++) begin
      absv[l]  = acc_in[l][ACC_W-1] ? (~acc_in[l] + 1'b1) : acc_in[l];
      rem_d[l] = rem_q[l];
      quo_d[l] = quo_q[l];
      neg_d[l] = neg_q[l];
      sat_d[l] = sat_q[l];
    end
    if (start_i) begin
      // quotient of 2^24 or more saturates either way
      for (int l = 0; l < 2; l++) begin
        rem_d[l] = absv[l][ACC_W-1:FRAC_SHIFT];
        quo_d[l] = '0;
        neg_d[l] = acc_in[l][ACC_W-1];
        sat_d[l] = absv[l][ACC_W-1:FRAC_SHIFT] >= (MAG_W'(pc_i) << DATA_W);
      end
      dsor_d = MAG_W'(pc_i) << (DATA_W - 1);
      cnt_d  = CNT_W'(DATA_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        ge       = rem_q[l] >= dsor_q;
        rem_d[l] = ge ? (rem_q[l] - dsor_q) : rem_q[l];
        quo_d[l] = {quo_q[l][DATA_W-2:0], ge};
      end
      dsor_d = dsor_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (neg_q[l]) begin
        res[l] = (sat_q[l] || quo_q[l] > NEG_LIM) ? NEG_LIM : (~quo_q[l] + 1'b1);
      end else begin
        res[l] = (sat_q[l] || quo_q[l] > POS_LIM) ? POS_LIM : quo_q[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dsor_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= '0;
        quo_q[l] <= '0;
        neg_q[l] <= 1'b0;
        sat_q[l] <= 1'b0;
      end
    end else begin
      dsor_q <= dsor_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_d[l];
        quo_q[l] <= quo_d[l];
        neg_q[l] <= neg_d[l];
        sat_q[l] <= sat_d[l];
      end
    end
  end

  assign done_o = done_q;
  assign q_r_o  = res[0];
  assign q_i_o  = res[1];

endmodule

[rtl/spectral_partitioned_convolver.sv]
// Top level: frequency-domain delay line and partition sequencer of the convolver.
// Load item: no result. Pass-through bin: via ST_FINISH to the output register.
// Convolution bin: the partition walk and normalization run on the single shared
// multiplier (four real products per partition) and the one-bit-a-cycle 24-step divider.
// The next item is taken once the current one has left for the output register.
// Reset: a clearing pass zeroes MAX_FRAMES*MAX_PARTS words of history and impulse RAMs,
// s_axis_tready_o stays low meanwhile; configuration writes are taken at any time.
module spectral_partitioned_convolver #(
  parameter int MAX_FRAMES = spc_pkg::DEF_MAX_FRAMES,
  parameter int MAX_PARTS  = spc_pkg::DEF_MAX_PARTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // cfg_data_i: frame_size (7 bits) or part_count (low 5 bits)
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: bin_real[23:0], bin_imag[47:24], coef_index[57:48],
  //        coef_real[81:58], coef_imag[105:82], zero fill [111:106]
  input  logic [spc_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser: command[0]
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: out_real[23:0], out_imag[47:24]
  output logic [spc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);

  import spc_pkg::*;

  localparam int DEPTH = MAX_FRAMES * MAX_PARTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(MAX_FRAMES);
  localparam int SW    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int PCW   = $clog2(MAX_PARTS + 1);
  localparam int ACC_W = 2 * DATA_W + 1 + PCW;
  localparam int XW    = AW + COEF_IDX_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ISSUE, ST_MUL, ST_DRAIN, ST_DIV_GO, ST_DIV_WAIT, ST_FINISH
  } state_e;

  typedef enum logic [1:0] {PR_RR, PR_II, PR_IR, PR_RI} prod_e;

  state_e               state_q, state_d;
  prod_e                k_q, k_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [FS_W-1:0]      fs_q, fs_d;
  logic [PC_CFG_W-1:0]  pc_q, pc_d;
  logic [BW-1:0]        bin_pos_q, bin_pos_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic [AW-1:0]        base_q, base_d;
  logic [AW-1:0]        ha_q, ha_d;
  logic [SW-1:0]        ws_q, ws_d;
  logic [AW-1:0]        ia_q, ia_d;
  logic [PCW-1:0]       part_q, part_d;
  logic [PCW-1:0]       npart_q, npart_d;
  logic                 last_q, last_d;
  logic [DATA_W-1:0]    res_r_q, res_r_d;
  logic [DATA_W-1:0]    res_i_q, res_i_d;
  logic                 m_valid_q, m_valid_d;
  logic [DATA_W-1:0]    m_real_q, m_real_d;
  logic [DATA_W-1:0]    m_imag_q, m_imag_d;
  logic                 m_last_q, m_last_d;

  logic                 in_take, is_load, is_proc, last_bin, idx_ok, part_end;
  logic [DATA_W-1:0]    in_real, in_imag, in_cre, in_cim;
  logic [COEF_IDX_W-1:0] in_idx;
  logic [XW-1:0]        idx_ext;
  logic [FS_W-1:0]      fs_eff;
  logic [PCW-1:0]       pc_eff;
  logic [BW-1:0]        b_eff;
  logic [AW-1:0]        ha_w, ha_nxt, ia_nxt;
  logic [SW-1:0]        ws_nxt;

  logic                 hist_we, imp_we, rd_en;
  logic [AW-1:0]        hist_waddr, imp_waddr, rd_haddr, rd_iaddr;
  logic [2*DATA_W-1:0]  hist_wdata, imp_wdata, hist_rdata, imp_rdata;

  mac_ctrl_t            mac_ctrl;
  logic signed [DATA_W-1:0] mac_a, mac_b;
  logic signed [ACC_W-1:0]  acc_r, acc_i;
  logic                 div_start, div_done;
  logic signed [DATA_W-1:0] q_r, q_i;

  assign in_real = s_axis_tdata_i[DATA_W-1:0];
  assign in_imag = s_axis_tdata_i[2*DATA_W-1:DATA_W];
  assign in_idx  = s_axis_tdata_i[2*DATA_W+COEF_IDX_W-1:2*DATA_W];
  assign in_cre  = s_axis_tdata_i[3*DATA_W+COEF_IDX_W-1:2*DATA_W+COEF_IDX_W];
  assign in_cim  = s_axis_tdata_i[4*DATA_W+COEF_IDX_W-1:3*DATA_W+COEF_IDX_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_take = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load = in_take && (s_axis_tuser_i == CMD_LOAD);
  assign is_proc = in_take && (s_axis_tuser_i == CMD_PROCESS);

  // effective frame size, partition count and bin position
  always_comb begin
    if (fs_q < FS_W'(FS_MIN)) begin
      fs_eff = FS_W'(FS_MIN);
    end else if (32'(fs_q) > MAX_FRAMES) begin
      fs_eff = FS_W'(MAX_FRAMES);
    end else begin
      fs_eff = fs_q;
    end
    pc_eff = (32'(pc_q) > MAX_PARTS) ? PCW'(MAX_PARTS) : PCW'(pc_q);
    b_eff  = (32'(bin_pos_q) > MAX_FRAMES - 1) ? BW'(MAX_FRAMES - 1) : bin_pos_q;
  end

  assign last_bin = 32'(b_eff) >= 32'(fs_eff) - 1;
  assign idx_ext  = XW'(in_idx);
  assign idx_ok   = 32'(in_idx) < DEPTH;
  assign ha_w     = AW'(32'(base_q) + 32'(b_eff));
  assign ha_nxt   = (ws_q == '0) ? AW'(32'(ha_q) + DEPTH - MAX_FRAMES)
                                 : AW'(32'(ha_q) - MAX_FRAMES);
  assign ws_nxt   = (ws_q == '0) ? SW'(MAX_PARTS - 1) : ws_q - 1'b1;
  assign ia_nxt   = AW'(32'(ia_q) + 32'(fs_eff));
  assign part_end = (PCW'(part_q + 1'b1) == npart_q);

  // RAM ports
  always_comb begin
    hist_we    = (state_q == ST_CLEAR) || (is_proc && pc_eff != '0);
    hist_waddr = (state_q == ST_CLEAR) ? clr_q : ha_w;
    hist_wdata = (state_q == ST_CLEAR) ? '0 : {in_imag, in_real};
    imp_we     = (state_q == ST_CLEAR) || (is_load && idx_ok);
    imp_waddr  = (state_q == ST_CLEAR) ? clr_q : idx_ext[AW-1:0];
    imp_wdata  = (state_q == ST_CLEAR) ? '0 : {in_cim, in_cre};
    rd_en      = 1'b0;
    rd_haddr   = ha_q;
    rd_iaddr   = ia_q;
    if (state_q == ST_ISSUE) begin
      rd_en = 1'b1;
    end else if (state_q == ST_MUL && k_q == PR_RI && !part_end) begin
      // fetch the next partition under the last product
      rd_en    = 1'b1;
      rd_haddr = ha_nxt;
      rd_iaddr = ia_nxt;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mac_ctrl     = '0;
    mac_ctrl.clr = is_proc;
    mac_a        = hist_rdata[DATA_W-1:0];
    mac_b        = imp_rdata[DATA_W-1:0];
    if (state_q == ST_MUL) begin
      mac_ctrl.en = 1'b1;
      case (k_q)
        PR_RR: begin
          mac_a = hist_rdata[DATA_W-1:0];
          mac_b = imp_rdata[DATA_W-1:0];
        end
        PR_II: begin
          mac_a        = hist_rdata[2*DATA_W-1:DATA_W];
          mac_b        = imp_rdata[2*DATA_W-1:DATA_W];
          mac_ctrl.neg = 1'b1;
        end
        PR_IR: begin
          mac_a       = hist_rdata[2*DATA_W-1:DATA_W];
          mac_b       = imp_rdata[DATA_W-1:0];
          mac_ctrl.im = 1'b1;
        end
        PR_RI: begin
          mac_a       = hist_rdata[DATA_W-1:0];
          mac_b       = imp_rdata[2*DATA_W-1:DATA_W];
          mac_ctrl.im = 1'b1;
        end
        default: begin
          mac_ctrl.en = 1'b0;
        end
      endcase
    end
  end

  assign div_start = (state_q == ST_DIV_GO);

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    clr_d     = clr_q;
    fs_d      = fs_q;
    pc_d      = pc_q;
    bin_pos_d = bin_pos_q;
    slot_d    = slot_q;
    base_d    = base_q;
    ha_d      = ha_q;
    ws_d      = ws_q;
    ia_d      = ia_q;
    part_d    = part_q;
    npart_d   = npart_q;
    last_d    = last_q;
    res_r_d   = res_r_q;
    res_i_d   = res_i_q;
    m_valid_d = m_valid_q;
    m_real_d  = m_real_q;
    m_imag_d  = m_imag_q;
    m_last_d  = m_last_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_SIZE: fs_d = cfg_data_i;
        CFG_PART_COUNT: pc_d = cfg_data_i[PC_CFG_W-1:0];
        default: ;
      endcase
    end

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (is_proc) begin
          last_d    = last_bin;
          bin_pos_d = last_bin ? '0 : BW'(b_eff + 1'b1);
          if (pc_eff == '0) begin
            res_r_d = in_real;
            res_i_d = in_imag;
            state_d = ST_FINISH;
          end else begin
            ha_d    = ha_w;
            ws_d    = slot_q;
            ia_d    = AW'(b_eff);
            part_d  = '0;
            npart_d = pc_eff;
            state_d = ST_ISSUE;
            // advance the ring after the last bin of the frame
            if (last_bin) begin
              if (slot_q == SW'(MAX_PARTS - 1)) begin
                slot_d = '0;
                base_d = '0;
              end else begin
                slot_d = slot_q + 1'b1;
                base_d = AW'(32'(base_q) + MAX_FRAMES);
              end
            end
          end
        end
      end
      ST_ISSUE: begin
        k_d     = PR_RR;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        case (k_q)
          PR_RR: k_d = PR_II;
          PR_II: k_d = PR_IR;
          PR_IR: k_d = PR_RI;
          PR_RI: begin
            k_d = PR_RR;
            if (part_end) begin
              state_d = ST_DRAIN;
            end else begin
              part_d = PCW'(part_q + 1'b1);
              ha_d   = ha_nxt;
              ws_d   = ws_nxt;
              ia_d   = ia_nxt;
            end
          end
          default: k_d = PR_RR;
        endcase
      end
      ST_DRAIN: begin
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_r_d = q_r;
          res_i_d = q_i;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_real_d  = res_r_q;
          m_imag_d  = res_i_q;
          m_last_d  = last_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      k_q       <= PR_RR;
      clr_q     <= '0;
      fs_q      <= FS_RESET;
      pc_q      <= PC_RESET;
      bin_pos_q <= '0;
      slot_q    <= '0;
      base_q    <= '0;
      ha_q      <= '0;
      ws_q      <= '0;
      ia_q      <= '0;
      part_q    <= '0;
      npart_q   <= '0;
      last_q    <= 1'b0;
      res_r_q   <= '0;
      res_i_q   <= '0;
      m_valid_q <= 1'b0;
      m_real_q  <= '0;
      m_imag_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      clr_q     <= clr_d;
      fs_q      <= fs_d;
      pc_q      <= pc_d;
      bin_pos_q <= bin_pos_d;
      slot_q    <= slot_d;
      base_q    <= base_d;
      ha_q      <= ha_d;
      ws_q      <= ws_d;
      ia_q      <= ia_d;
      part_q    <= part_d;
      npart_q   <= npart_d;
      last_q    <= last_d;
      res_r_q   <= res_r_d;
      res_i_q   <= res_i_d;
      m_valid_q <= m_valid_d;
      m_real_q  <= m_real_d;
      m_imag_q  <= m_imag_d;
      m_last_q  <= m_last_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_imag_q, m_real_q};
  assign m_axis_tlast_o  = m_last_q;

  spc_ram #(.WIDTH(2 * DATA_W), .DEPTH(DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_haddr),
    .rdata_o (hist_rdata)
  );

  spc_ram #(.WIDTH(2 * DATA_W), .DEPTH(DEPTH)) u_imp_ram (
    .clk_i   (clk_i),
    .we_i    (imp_we),
    .waddr_i (imp_waddr),
    .wdata_i (imp_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_iaddr),
    .rdata_o (imp_rdata)
  );

  spc_mac #(.ACC_W(ACC_W)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .acc_r_o (acc_r),
    .acc_i_o (acc_i)
  );

  spc_div #(.ACC_W(ACC_W), .PCW(PCW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .pc_i    (npart_q),
    .acc_r_i (acc_r),
    .acc_i_i (acc_i),
    .done_o  (div_done),
    .q_r_o   (q_r),
    .q_i_o   (q_i)
  );

  // no item taken while the clearing pass runs
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("item taken during clearing pass");

  // the partition walk never passes the partition count
  a_part_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (part_q < npart_q))
    else $error("partition counter out of range");

  // the divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT))
    else $error("divider result with no waiting sequencer");

  // a convolution bin starts its partition walk right after accept
  a_conv_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_proc && pc_eff != '0) |=> (state_q == ST_ISSUE))
    else $error("convolution bin did not start its walk");

  // a new result is loaded only from the finish step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FINISH))
    else $error("result shown outside finish step");

endmodule

[test/tb_spectral_partitioned_convolver.sv]
// Self-checking testbench of the spectral partitioned convolver: stream stimulus and bin prediction.
`timescale 1ns / 1ps

module tb_spectral_partitioned_convolver;

  import spc_pkg::*;

  localparam int NUM_FRAMES = DEF_MAX_FRAMES;
  localparam int NUM_PARTS  = DEF_MAX_PARTS;
  localparam int RAM_DEPTH  = NUM_FRAMES * NUM_PARTS;
  localparam int SETTLE_CYC = 200;   // well past the longest convolution bin
  localparam int QUIET_MAX  = 5000;  // covers the clearing pass after reset

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct {
    logic                  cmd;
    sample_t               bin_re;
    sample_t               bin_im;
    logic [COEF_IDX_W-1:0] cidx;
    sample_t               coef_re;
    sample_t               coef_im;
  } bin_item_t;

  typedef struct {
    sample_t re;
    sample_t im;
    logic    last;
  } out_bin_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   cfg_ready_o;
  logic                   s_valid   = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic                   m_ready   = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;

  spectral_partitioned_convolver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Predictor state
  sample_t          hist_re [RAM_DEPTH];
  sample_t          hist_im [RAM_DEPTH];
  sample_t          imp_re  [RAM_DEPTH];
  sample_t          imp_im  [RAM_DEPTH];
  int unsigned      bin_pos;
  int unsigned      newest_slot;
  logic [FS_W-1:0]  frame_size_reg;
  logic [PC_CFG_W-1:0] part_count_reg;

  bin_item_t pending_items[$];
  out_bin_t  expected_bins[$];
  bin_item_t presented;
  int        mismatches   = 0;
  int        quiet_cycles = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic sample_t clamp24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[DATA_W-1:0];
  endfunction

  // Apply one accepted item to the predictor and queue the bin that a process item produces.
  task automatic predict_bin(input bin_item_t it);
    int unsigned fs, pc, b, slot, s, ha, ia;
    longint      acc_re, acc_im, hr, hi, cr, ci, divisor;
    bit          last;
    out_bin_t    r;
    if (it.cmd == CMD_LOAD) begin
      imp_re[it.cidx] = it.coef_re;
      imp_im[it.cidx] = it.coef_im;
      return;
    end
    fs = frame_size_reg;
    if (fs < FS_MIN) fs = FS_MIN;
    if (fs > NUM_FRAMES) fs = NUM_FRAMES;
    pc = part_count_reg;
    if (pc > NUM_PARTS) pc = NUM_PARTS;
    b = (bin_pos >= NUM_FRAMES) ? NUM_FRAMES - 1 : bin_pos;
    last = (b >= fs - 1);
    if (pc == 0) begin
      r.re = it.bin_re;
      r.im = it.bin_im;
    end else begin
      slot = newest_slot % NUM_PARTS;
      hist_re[slot * NUM_FRAMES + b] = it.bin_re;
      hist_im[slot * NUM_FRAMES + b] = it.bin_im;
      acc_re = 0;
      acc_im = 0;
      for (int unsigned p = 0; p < pc; p++) begin
        s  = (slot + NUM_PARTS - p) % NUM_PARTS;
        ha = s * NUM_FRAMES + b;
        ia = p * fs + b;
        if (ia < RAM_DEPTH) begin
          hr = hist_re[ha];
          hi = hist_im[ha];
          cr = imp_re[ia];
          ci = imp_im[ia];
          acc_re += hr * cr - hi * ci;
          acc_im += hi * cr + hr * ci;
        end
      end
      divisor = longint'(pc) <<< FRAC_SHIFT;
      r.re = clamp24(acc_re / divisor);
      r.im = clamp24(acc_im / divisor);
    end
    r.last = last;
    expected_bins.push_back(r);
    if (last) begin
      bin_pos = 0;
      if (pc != 0) newest_slot = (newest_slot + 1 >= NUM_PARTS) ? 0 : newest_slot + 1;
    end else begin
      bin_pos = b + 1;
    end
  endtask

  // Driver, predictor update and watchdog
  always @(posedge clk_i) begin
    if (s_valid && s_axis_tready_o) predict_bin(presented);
    if (cfg_valid && cfg_ready_o) begin
      if (cfg_index == CFG_FRAME_SIZE) frame_size_reg = cfg_data[FS_W-1:0];
      else if (cfg_index == CFG_PART_COUNT) part_count_reg = cfg_data[PC_CFG_W-1:0];
    end
    if ((s_valid && s_axis_tready_o) || (cfg_valid && cfg_ready_o) ||
        (m_axis_tvalid_o === 1'b1 && m_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("tb_spectral_partitioned_convolver NOT OK");
      $finish;
    end
    if (!s_valid || s_axis_tready_o) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        presented = pending_items.pop_front();
        s_valid <= 1'b1;
        s_tuser <= presented.cmd;
        s_tdata <= {6'b0, presented.coef_im, presented.coef_re, presented.cidx,
                    presented.bin_im, presented.bin_re};
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    out_bin_t want;
    if (m_axis_tvalid_o === 1'b1 && m_ready) begin
      if (expected_bins.size() == 0) begin
        $error("output bin with no expectation pending");
        mismatches++;
      end else begin
        want = expected_bins.pop_front();
        if (m_axis_tdata_o[23:0] !== want.re) begin
          $error("out_real: expected %0d, got %0d", want.re, $signed(m_axis_tdata_o[23:0]));
          mismatches++;
        end
        if (m_axis_tdata_o[47:24] !== want.im) begin
          $error("out_imag: expected %0d, got %0d", want.im, $signed(m_axis_tdata_o[47:24]));
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("frame_last: expected %0d, got %0d", want.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
    m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return ($urandom_range(0, 1)) ? 24'sh200000 : -24'sh200000;
      3, 4:    return DATA_W'($urandom_range(0, 1 << 22) - (1 << 21));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic bin_item_t mk_item(input logic cmd, input sample_t br, input sample_t bi,
                                        input int idx, input sample_t cr, input sample_t ci);
    bin_item_t it;
    it.cmd     = cmd;
    it.bin_re  = br;
    it.bin_im  = bi;
    it.cidx    = COEF_IDX_W'(idx);
    it.coef_re = cr;
    it.coef_im = ci;
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int fs, input int pc);
    write_reg(CFG_FRAME_SIZE, CFG_DATA_W'(fs));
    // upper data bits are don't-care for the partition count
    write_reg(CFG_PART_COUNT, {(CFG_DATA_W - PC_CFG_W)'($urandom_range(0, 3)),
                               pc[PC_CFG_W-1:0]});
  endtask

  // Hold until every item has gone in and every bin has come out, then settle.
  task automatic drain();
    while (pending_items.size() != 0 || s_valid || expected_bins.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic run_phase(input int fs, input int pc, input int count);
    int        fs_eff, pc_eff, span;
    bin_item_t it;
    fs_eff = (fs < FS_MIN) ? FS_MIN : (fs > NUM_FRAMES) ? NUM_FRAMES : fs;
    pc_eff = (pc > NUM_PARTS) ? NUM_PARTS : pc;
    span   = fs_eff * pc_eff;
    configure(fs, pc);
    for (int n = 0; n < count; n++) begin
      it.cmd     = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_PROCESS;
      it.bin_re  = rand_sample();
      it.bin_im  = rand_sample();
      it.coef_re = rand_sample();
      it.coef_im = rand_sample();
      // aim most loads at coefficients in use
      it.cidx    = COEF_IDX_W'((span != 0 && $urandom_range(0, 3) != 0)
                               ? $urandom_range(0, span - 1)
                               : $urandom_range(0, RAM_DEPTH - 1));
      pending_items.push_back(it);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < RAM_DEPTH; i++) begin
      hist_re[i] = '0;
      hist_im[i] = '0;
      imp_re[i]  = '0;
      imp_im[i]  = '0;
    end
    bin_pos        = 0;
    newest_slot    = 0;
    frame_size_reg = FS_RESET;
    part_count_reg = PC_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 20;
    snk_idle_pct = 48;
    configure(4, 2);
    // full-scale and unit coefficients, top address
    pending_items.push_back(mk_item(CMD_LOAD, 0, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF));
    pending_items.push_back(mk_item(CMD_LOAD, 0, 0, 1, 24'sh800000, 24'sh800000));
    pending_items.push_back(mk_item(CMD_LOAD, 0, 0, 2, 24'sh200000, 0));
    pending_items.push_back(mk_item(CMD_LOAD, 0, 0, 3, 0, -24'sh200000));
    pending_items.push_back(mk_item(CMD_LOAD, 0, 0, 4, 24'sh800000, 24'sh7FFFFF));
    pending_items.push_back(mk_item(CMD_LOAD, 0, 0, 5, 24'sh200000, 24'sh200000));
    pending_items.push_back(mk_item(CMD_LOAD, 0, 0, 6, 24'sh7FFFFF, 0));
    pending_items.push_back(mk_item(CMD_LOAD, 0, 0, 7, 0, 24'sh800000));
    pending_items.push_back(mk_item(CMD_LOAD, -1, -1, RAM_DEPTH - 1, 24'sh7FFFFF, 24'sh800000));
    // two frames of extreme bins drive the sums into saturation
    pending_items.push_back(mk_item(CMD_PROCESS, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0));
    pending_items.push_back(mk_item(CMD_PROCESS, 24'sh800000, 24'sh800000, 0, 0, 0));
    pending_items.push_back(mk_item(CMD_PROCESS, 24'sh7FFFFF, 24'sh800000, 0, 0, 0));
    pending_items.push_back(mk_item(CMD_PROCESS, 0, 0, RAM_DEPTH - 1, -1, -1));
    pending_items.push_back(mk_item(CMD_PROCESS, 24'sh800000, 24'sh7FFFFF, 0, 0, 0));
    pending_items.push_back(mk_item(CMD_PROCESS, 1, -1, 0, 0, 0));
    pending_items.push_back(mk_item(CMD_PROCESS, -1, -1, 0, 0, 0));
    pending_items.push_back(mk_item(CMD_PROCESS, 24'sh7FFFFF, 0, 0, 0, 0));
    pending_items.push_back(mk_item(CMD_LOAD, 0, 0, 4, 24'sh200000, -24'sh200000));
    pending_items.push_back(mk_item(CMD_PROCESS, 24'sh123456, -24'sh123456, 0, 0, 0));
    drain();

    run_phase(4, 16, 90);
    run_phase(8, 3, 70);

    src_idle_pct = 48;
    snk_idle_pct = 20;
    run_phase(5, 0, 40);
    run_phase(64, 16, 60);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(127, 31, 60);  // both beyond their maximum
    run_phase(2, 1, 70);     // below the minimum, lowered mid-frame

    if (mismatches == 0) begin
      $display("tb_spectral_partitioned_convolver OK");
    end else begin
      $display("tb_spectral_partitioned_convolver NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/spc_pkg.sv
rtl/spc_ram.sv
rtl/spc_mac.sv
rtl/spc_div.sv
rtl/spectral_partitioned_convolver.sv
test/tb_spectral_partitioned_convolver.sv
